// ===== src/i2a_pkg.sv =====
// shared types, constants and helpers for the integer to ascii converter
package i2a_pkg;

   localparam int VALUE_WIDTH_DEF = 32;
   localparam int VALUE_BITS = 32;
   localparam int CHAR_BITS = 8;
   localparam int DIGIT_BITS = 4;

   localparam logic [CHAR_BITS-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_NINE = 8'h39;
   localparam logic [CHAR_BITS-1:0] CHAR_HEX_OFS = 8'h57;
   localparam logic [CHAR_BITS-1:0] CHAR_HEX_LO = 8'h61;
   localparam logic [CHAR_BITS-1:0] CHAR_HEX_HI = 8'h66;
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2d;

   localparam logic [DIGIT_BITS-1:0] DIGIT_ADJ_MIN = 4'd5;
   localparam logic [DIGIT_BITS-1:0] DIGIT_ADJ = 4'd3;
   localparam logic [DIGIT_BITS-1:0] DIGIT_TEN = 4'd10;

   typedef enum logic {
      MODE_DEC = 1'b0,
      MODE_HEX = 1'b1
   } mode_type;

   typedef struct packed {
      logic                  req_type;
      logic [VALUE_BITS-1:0] value;
   } req_payload_type;

   typedef struct packed {
      logic [CHAR_BITS-1:0] char_code;
      logic                 last;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_CLEAR,
      CELL_BIT,
      CELL_DIGIT
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        dec;
   } cell_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_SIGN,
      ST_EMIT
   } state_type;

   function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d);
      logic [CHAR_BITS-1:0] wide;
      wide = {{(CHAR_BITS-DIGIT_BITS){1'b0}}, d};
      if (d >= DIGIT_TEN) begin
         digit_char = wide + CHAR_HEX_OFS;
      end else begin
         digit_char = wide + CHAR_ZERO;
      end
   endfunction

endpackage

// ===== src/int_to_ascii_digits.sv =====
// Converts one word per request to ASCII text, signed decimal or lower-case hex, one
// character per response, most significant first, last flagged. The low VALUE_WIDTH bits
// of value are shifted one bit per cycle into a chain of digit cells (add-3 correction in
// decimal mode, plain nibble shift in hex), then leading zero digits are shifted out one
// per cycle and the remaining digits are sent one per cycle while the response side is
// ready, after a minus sign for a negative decimal value. At 32 bits the chain has 10 cells.
// A new request is taken only once the previous one has handed out its last character,
// which may still sit in the output register.
module int_to_ascii_digits #(
   parameter int VALUE_WIDTH = i2a_pkg::VALUE_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  i2a_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output i2a_pkg::rsp_payload_type rsp_data
);

   // decimal digits of 2^(W-1), hex digits of 2^W - 1
   localparam int DecDigits = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
   localparam int HexDigits = (VALUE_WIDTH + 3) / 4;
   localparam int NumCells  = (DecDigits > HexDigits) ? DecDigits : HexDigits;
   localparam int BitCntW   = $clog2(VALUE_WIDTH + 1);
   localparam int DigCntW   = $clog2(NumCells + 1);
   localparam logic [BitCntW-1:0] BitCntInit = BitCntW'(VALUE_WIDTH);
   localparam logic [DigCntW-1:0] DigCntInit = DigCntW'(NumCells);
   localparam logic [BitCntW-1:0] BitCntOne  = BitCntW'(1);
   localparam logic [DigCntW-1:0] DigCntOne  = DigCntW'(1);

   i2a_pkg::state_type state_ff, state_in;

   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic                   neg_ff, neg_in;
   logic                   mode_ff, mode_in;
   logic [BitCntW-1:0]     bit_cnt_ff, bit_cnt_in;
   logic [DigCntW-1:0]     dig_cnt_ff, dig_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   i2a_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic [VALUE_WIDTH-1:0] word;
   logic                   word_neg;
   logic                   out_free;
   logic                   top_zero;
   logic                   more_digits;
   logic                   accept;
   logic                   emit_sign;
   logic                   emit_digit;
   i2a_pkg::cell_ctrl_type cell_ctrl;

   logic [NumCells-1:0]                    carry;
   logic [i2a_pkg::DIGIT_BITS-1:0]         digits [NumCells];
   logic [i2a_pkg::DIGIT_BITS-1:0]         top_digit;

   assign word        = VALUE_WIDTH'(req_data.value);
   assign word_neg    = (req_data.req_type == i2a_pkg::MODE_DEC) && word[VALUE_WIDTH-1];
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign top_digit   = digits[NumCells-1];
   assign top_zero    = (top_digit == '0);
   assign more_digits = (dig_cnt_ff > DigCntOne);

   // cell chain
   for (genvar i = 0; i < NumCells; i++) begin : g_cell
      logic                           bit_in;
      logic [i2a_pkg::DIGIT_BITS-1:0] lower_digit;
      if (i == 0) begin : g_first
         assign bit_in      = mag_ff[VALUE_WIDTH-1];
         assign lower_digit = '0;
      end else begin : g_rest
         assign bit_in      = carry[i-1];
         assign lower_digit = digits[i-1];
      end
      i2a_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl),
         .bit_in      (bit_in),
         .lower_digit (lower_digit),
         .carry_out   (carry[i]),
         .digit       (digits[i])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         i2a_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = i2a_pkg::ST_CONVERT;
            end
         end
         i2a_pkg::ST_CONVERT: begin
            if (bit_cnt_ff == BitCntOne) begin
               state_in = i2a_pkg::ST_SKIP;
            end
         end
         i2a_pkg::ST_SKIP: begin
            if (!(top_zero && more_digits)) begin
               state_in = neg_ff ? i2a_pkg::ST_SIGN : i2a_pkg::ST_EMIT;
            end
         end
         i2a_pkg::ST_SIGN: begin
            if (out_free) begin
               state_in = i2a_pkg::ST_EMIT;
            end
         end
         i2a_pkg::ST_EMIT: begin
            if (out_free && !more_digits) begin
               state_in = i2a_pkg::ST_IDLE;
            end
         end
         default: state_in = i2a_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready     = 1'b0;
      accept        = 1'b0;
      emit_sign     = 1'b0;
      emit_digit    = 1'b0;
      cell_ctrl.op  = i2a_pkg::CELL_HOLD;
      cell_ctrl.dec = (mode_ff == i2a_pkg::MODE_DEC);
      case (state_ff)
         i2a_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               accept       = 1'b1;
               cell_ctrl.op = i2a_pkg::CELL_CLEAR;
            end
         end
         i2a_pkg::ST_CONVERT: begin
            cell_ctrl.op = i2a_pkg::CELL_BIT;
         end
         i2a_pkg::ST_SKIP: begin
            if (top_zero && more_digits) begin
               cell_ctrl.op = i2a_pkg::CELL_DIGIT;
            end
         end
         i2a_pkg::ST_SIGN: begin
            emit_sign = out_free;
         end
         i2a_pkg::ST_EMIT: begin
            emit_digit = out_free;
            if (out_free) begin
               cell_ctrl.op = i2a_pkg::CELL_DIGIT;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // datapath registers
   always_comb begin
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      mode_in      = mode_ff;
      bit_cnt_in   = bit_cnt_ff;
      dig_cnt_in   = dig_cnt_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (accept) begin
         mag_in     = word_neg ? (~word + VALUE_WIDTH'(1)) : word;
         neg_in     = word_neg;
         mode_in    = req_data.req_type;
         bit_cnt_in = BitCntInit;
         dig_cnt_in = DigCntInit;
      end
      if (cell_ctrl.op == i2a_pkg::CELL_BIT) begin
         mag_in     = mag_ff << 1;
         bit_cnt_in = bit_cnt_ff - BitCntOne;
      end
      if (cell_ctrl.op == i2a_pkg::CELL_DIGIT) begin
         dig_cnt_in = dig_cnt_ff - DigCntOne;
      end
      if (emit_sign) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.char_code = i2a_pkg::CHAR_MINUS;
         rsp_data_in.last      = 1'b0;
      end
      if (emit_digit) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.char_code = i2a_pkg::digit_char(top_digit);
         rsp_data_in.last      = !more_digits;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= i2a_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      mode_ff     <= mode_in;
      bit_cnt_ff  <= bit_cnt_in;
      dig_cnt_ff  <= dig_cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== src/i2a_cell.sv =====
// one digit cell of the shift-and-adjust conversion chain
module i2a_cell (
   input  logic                             clock,
   input  i2a_pkg::cell_ctrl_type           ctrl,
   input  logic                             bit_in,
   input  logic [i2a_pkg::DIGIT_BITS-1:0]   lower_digit,
   output logic                             carry_out,
   output logic [i2a_pkg::DIGIT_BITS-1:0]   digit
);

   logic [i2a_pkg::DIGIT_BITS-1:0] digit_ff;
   logic [i2a_pkg::DIGIT_BITS-1:0] digit_in;
   logic [i2a_pkg::DIGIT_BITS-1:0] adj;

   // add-3 correction keeps the nibble a valid bcd digit after the doubling
   always_comb begin
      if (ctrl.dec && digit_ff >= i2a_pkg::DIGIT_ADJ_MIN) begin
         adj = digit_ff + i2a_pkg::DIGIT_ADJ;
      end else begin
         adj = digit_ff;
      end
   end

   always_comb begin
      case (ctrl.op)
         i2a_pkg::CELL_HOLD:  digit_in = digit_ff;
         i2a_pkg::CELL_CLEAR: digit_in = '0;
         i2a_pkg::CELL_BIT:   digit_in = {adj[i2a_pkg::DIGIT_BITS-2:0], bit_in};
         i2a_pkg::CELL_DIGIT: digit_in = lower_digit;
         default:             digit_in = digit_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign carry_out = adj[i2a_pkg::DIGIT_BITS-1];
   assign digit     = digit_ff;

endmodule

// ===== src/i2a_checker.sv =====
// port-level checks for the integer to ascii converter, bound to the top level
module i2a_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input i2a_pkg::rsp_payload_type rsp_data
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // one request at a time: busy right after an accepted request
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a conversion runs");

   // a minus sign never ends a conversion
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.char_code == i2a_pkg::CHAR_MINUS |-> !rsp_data.last)
      else $error("minus sign flagged as last");

   // only digits, lower-case hex letters and minus come out
   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_data.char_code >= i2a_pkg::CHAR_ZERO && rsp_data.char_code <= i2a_pkg::CHAR_NINE)
         || (rsp_data.char_code >= i2a_pkg::CHAR_HEX_LO
             && rsp_data.char_code <= i2a_pkg::CHAR_HEX_HI)
         || rsp_data.char_code == i2a_pkg::CHAR_MINUS)
      else $error("unexpected character code");

endmodule

bind int_to_ascii_digits i2a_checker u_i2a_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== tb/tb_int_to_ascii_digits.sv =====
// testbench for int_to_ascii_digits: random and directed conversions checked per character
`timescale 1ns / 1ps

module tb_int_to_ascii_digits;

   localparam int RANDOM_COUNT = 300;
   localparam int TAIL_ITEMS = 40;
   localparam int LONG_HOLD = 250;
   localparam int STALL_LIMIT = 3000;

   typedef struct {
      i2a_pkg::req_payload_type payload;
      bit                       wait_drain;
   } conversion_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   i2a_pkg::req_payload_type req_data = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   i2a_pkg::rsp_payload_type rsp_data;

   conversion_type           conversions_queued[$];
   i2a_pkg::rsp_payload_type expected_text[$];
   int                       chars_predicted = 0;
   int                       chars_seen = 0;
   int                       requests_taken = 0;
   int                       dec_taken = 0;
   int                       hex_taken = 0;
   int                       fail_count = 0;
   bit                       tail_phase = 1'b0;
   bit                       stalling = 1'b0;

   int_to_ascii_digits DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // expected text of one request, most significant character first
   function automatic void predict_text(input i2a_pkg::req_payload_type r);
      logic [i2a_pkg::VALUE_BITS-1:0] mag;
      logic [i2a_pkg::VALUE_BITS-1:0] rem;
      logic [i2a_pkg::CHAR_BITS-1:0]  digits[$];
      logic [i2a_pkg::CHAR_BITS-1:0]  wide;
      logic [i2a_pkg::DIGIT_BITS-1:0] d;
      bit                             neg;
      i2a_pkg::rsp_payload_type       ch;
      neg = (r.req_type == i2a_pkg::MODE_DEC) && r.value[i2a_pkg::VALUE_BITS-1];
      mag = neg ? -r.value : r.value;
      do begin
         if (r.req_type == i2a_pkg::MODE_HEX) begin
            d = mag[i2a_pkg::DIGIT_BITS-1:0];
            mag = mag >> i2a_pkg::DIGIT_BITS;
         end else begin
            rem = mag % 10;
            d = rem[i2a_pkg::DIGIT_BITS-1:0];
            mag = mag / 10;
         end
         wide = {{(i2a_pkg::CHAR_BITS-i2a_pkg::DIGIT_BITS){1'b0}}, d};
         if (d >= i2a_pkg::DIGIT_TEN) begin
            digits.push_front(wide + i2a_pkg::CHAR_HEX_OFS);
         end else begin
            digits.push_front(wide + i2a_pkg::CHAR_ZERO);
         end
      end while (mag != 0);
      if (neg) begin
         digits.push_front(i2a_pkg::CHAR_MINUS);
      end
      foreach (digits[k]) begin
         ch.char_code = digits[k];
         ch.last = (k == digits.size() - 1);
         expected_text.push_back(ch);
         chars_predicted++;
      end
      if (r.req_type == i2a_pkg::MODE_HEX) begin
         hex_taken++;
      end else begin
         dec_taken++;
      end
   endfunction

   task automatic add_conversion(input i2a_pkg::mode_type mode,
                                 input logic [i2a_pkg::VALUE_BITS-1:0] value,
                                 input bit wait_drain);
      conversion_type c;
      c.payload.req_type = mode;
      c.payload.value = value;
      c.wait_drain = wait_drain;
      conversions_queued.push_back(c);
   endtask

   // values biased toward digit-count boundaries, small magnitudes and the sign edge
   function automatic logic [i2a_pkg::VALUE_BITS-1:0] random_word();
      logic [i2a_pkg::VALUE_BITS-1:0] p;
      p = 1;
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 99);
         1: begin
            repeat ($urandom_range(0, 9)) p = p * 10;
            return p + $urandom_range(0, 2) - 1;
         end
         2: return -$urandom_range(1, 1000);
         3: return $urandom >> $urandom_range(0, 31);
         4: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'hffff_ffff;
               default: return '0;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   // request driver
   int send_gap = 0;
   always @(posedge clock) begin
      conversion_type c;
      int             idle_level;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_text(req_data);
            requests_taken++;
         end
         if (conversions_queued.size() < TAIL_ITEMS) begin
            tail_phase <= 1'b1;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (conversions_queued.size() != 0 &&
                         (!conversions_queued[0].wait_drain ||
                          chars_seen == chars_predicted)) begin
               c = conversions_queued.pop_front();
               req_valid <= 1'b1;
               req_data <= c.payload;
               idle_level = (requests_taken / 25) % 3;
               if (!tail_phase && !stalling && $urandom_range(0, 3) < idle_level) begin
                  send_gap = $urandom_range(1, 17);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and ready generator
   int  take_gap = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   always @(posedge clock) begin
      i2a_pkg::rsp_payload_type want;
      int                       idle_level;
      if (reset) begin
         rsp_ready <= 1'b0;
         take_gap = 0;
         hold_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            chars_seen <= chars_seen + 1;
            if (expected_text.size() == 0) begin
               $error("response with no request pending: char_code %h last %b",
                      rsp_data.char_code, rsp_data.last);
               fail_count++;
            end else begin
               want = expected_text.pop_front();
               if (rsp_data.char_code !== want.char_code) begin
                  $error("char_code mismatch: expected %h, actual %h",
                         want.char_code, rsp_data.char_code);
                  fail_count++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last mismatch: expected %b, actual %b", want.last, rsp_data.last);
                  fail_count++;
               end
            end
         end
         // one long hold mid-run while the sender keeps offering
         if (!hold_done && chars_seen >= 400) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (take_gap > 0) begin
            take_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            idle_level = (chars_seen / 80) % 3;
            if (!tail_phase && $urandom_range(0, 3) < idle_level) begin
               take_gap = $urandom_range(1, 17);
            end
         end
         stalling <= (hold_left > 0);
      end
   end

   // watchdog on cycles with no handshake on either side
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      // zero, sign edge, all ones, digit-count boundaries, every hex letter
      add_conversion(i2a_pkg::MODE_DEC, 32'h0000_0000, 1'b0);
      add_conversion(i2a_pkg::MODE_HEX, 32'h0000_0000, 1'b0);
      add_conversion(i2a_pkg::MODE_DEC, 32'h8000_0000, 1'b0);
      add_conversion(i2a_pkg::MODE_HEX, 32'h8000_0000, 1'b0);
      add_conversion(i2a_pkg::MODE_DEC, 32'hffff_ffff, 1'b0);
      add_conversion(i2a_pkg::MODE_HEX, 32'hffff_ffff, 1'b0);
      add_conversion(i2a_pkg::MODE_DEC, 32'h7fff_ffff, 1'b0);
      add_conversion(i2a_pkg::MODE_HEX, 32'h7fff_ffff, 1'b0);
      add_conversion(i2a_pkg::MODE_DEC, 32'd1, 1'b0);
      add_conversion(i2a_pkg::MODE_DEC, 32'd9, 1'b0);
      add_conversion(i2a_pkg::MODE_DEC, 32'd10, 1'b0);
      add_conversion(i2a_pkg::MODE_DEC, 32'd1000000000, 1'b0);
      add_conversion(i2a_pkg::MODE_DEC, 32'd999999999, 1'b0);
      add_conversion(i2a_pkg::MODE_DEC, -32'd10, 1'b0);
      add_conversion(i2a_pkg::MODE_DEC, 32'h8000_0001, 1'b0);
      add_conversion(i2a_pkg::MODE_HEX, 32'd9, 1'b0);
      add_conversion(i2a_pkg::MODE_HEX, 32'd10, 1'b0);
      add_conversion(i2a_pkg::MODE_HEX, 32'd15, 1'b0);
      add_conversion(i2a_pkg::MODE_HEX, 32'd16, 1'b0);
      add_conversion(i2a_pkg::MODE_HEX, 32'h0123_4567, 1'b0);
      add_conversion(i2a_pkg::MODE_HEX, 32'h89ab_cdef, 1'b0);
      add_conversion(i2a_pkg::MODE_HEX, 32'h1000_0000, 1'b0);
      // first random request waits for the directed text to drain
      for (int i = 0; i < RANDOM_COUNT; i++) begin
         add_conversion($urandom_range(0, 1) ? i2a_pkg::MODE_HEX : i2a_pkg::MODE_DEC,
                        random_word(), (i == 0) || ($urandom_range(0, 39) == 0));
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (conversions_queued.size() != 0 || req_valid || chars_seen != chars_predicted);
      repeat (100) @(negedge clock);

      if (expected_text.size() != 0) begin
         $error("%0d characters never arrived", expected_text.size());
         fail_count++;
      end
      $display("converted %0d requests (%0d decimal, %0d hex), %0d characters checked",
               requests_taken, dec_taken, hex_taken, chars_seen);
      $display("included zero, sign edge, all ones, digit boundaries, long response stall");
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
